// File: design/tcfq_pkg.sv
// Shared types, constants and register codes of the temperature channel fault qualifier.
// No dependencies; imported by tcfq_cfg, tcfq_eval and the top module.
package tcfq_pkg;

    localparam int CHANNELS_DEF = 4;
    localparam int CH_W         = 2;
    localparam int VCODE_W      = 16;
    localparam int TEMP_W       = 13;
    localparam int TIME_W       = 32;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CH_W-1:0] MOTOR_CH = CH_W'(3);

    // Reset values of the configuration registers.
    localparam logic [3:0]         ENABLE_RST  = 4'd8;
    localparam logic [15:0]        OPEN_RST    = 16'd64880;
    localparam logic [15:0]        SHORT_RST   = 16'd655;
    localparam logic [15:0]        SUSTAIN_RST = 16'd1000;
    localparam logic [7:0]         HYST_RST    = 8'd50;
    localparam logic [TEMP_W-1:0]  CRIT_INV_RST = 13'sd900;
    localparam logic [TEMP_W-1:0]  CRIT_MOT_RST = 13'sd1500;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ENABLE_MASK   = 3'd0,
        CFG_OPEN_LEVEL    = 3'd1,
        CFG_SHORT_LEVEL   = 3'd2,
        CFG_SUSTAIN_MS    = 3'd3,
        CFG_HYSTERESIS    = 3'd4,
        CFG_CRIT_INVERTER = 3'd5,
        CFG_CRIT_MOTOR    = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_OPEN      = 2'd1,
        EV_SHORT     = 2'd2,
        EV_OVER_TEMP = 2'd3
    } t_event;

    typedef struct packed {
        logic [3:0]               enable_mask;
        logic [15:0]              open_level;
        logic [15:0]              short_level;
        logic [15:0]              sustain_ms;
        logic [7:0]               hysteresis;
        logic signed [TEMP_W-1:0] crit_inverter;
        logic signed [TEMP_W-1:0] crit_motor;
    } t_cfg;

    // One memory word per channel.
    typedef struct packed {
        logic              range_pending;
        logic [TIME_W-1:0] range_start;
        logic              range_confirmed;
        logic              heat_condition;
        logic [TIME_W-1:0] heat_start;
        logic              heat_reported;
    } t_chan_state;

    localparam int STATE_W = $bits(t_chan_state);

    typedef struct packed {
        logic       range_fault;
        logic       over_temp_active;
        logic       temp_usable;
        t_event     fault_event;
    } t_result;

endpackage

// File: design/tcfq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module tcfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic                                          i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns the old contents when the same entry is written in that cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/tcfq_cfg.sv
// Configuration register file of the fault qualifier.
// Depends on tcfq_pkg for register codes, reset values and the t_cfg struct.
module tcfq_cfg
    import tcfq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_ADDR_W-1:0] i_addr,
    input  logic [CFG_DATA_W-1:0] i_wdata,
    output t_cfg                  o_cfg
);
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable_mask   <= ENABLE_RST;
            r_cfg.open_level    <= OPEN_RST;
            r_cfg.short_level   <= SHORT_RST;
            r_cfg.sustain_ms    <= SUSTAIN_RST;
            r_cfg.hysteresis    <= HYST_RST;
            r_cfg.crit_inverter <= CRIT_INV_RST;
            r_cfg.crit_motor    <= CRIT_MOT_RST;
        end else if (i_we) begin
            case (t_cfg_idx'(i_addr))
                CFG_ENABLE_MASK:   r_cfg.enable_mask   <= i_wdata[3:0];
                CFG_OPEN_LEVEL:    r_cfg.open_level    <= i_wdata;
                CFG_SHORT_LEVEL:   r_cfg.short_level   <= i_wdata;
                CFG_SUSTAIN_MS:    r_cfg.sustain_ms    <= i_wdata;
                CFG_HYSTERESIS:    r_cfg.hysteresis    <= i_wdata[7:0];
                CFG_CRIT_INVERTER: r_cfg.crit_inverter <= i_wdata[TEMP_W-1:0];
                CFG_CRIT_MOTOR:    r_cfg.crit_motor    <= i_wdata[TEMP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/tcfq_eval.sv
// Per-request update of one channel's state: open/short qualification and
// over-temperature with hysteresis. Depends on tcfq_pkg.
module tcfq_eval
    import tcfq_pkg::*;
(
    input  t_cfg                     i_cfg,
    input  t_chan_state              i_state,
    input  logic [CH_W-1:0]          i_channel,
    input  logic [VCODE_W-1:0]       i_voltage_code,
    input  logic signed [TEMP_W-1:0] i_temperature,
    input  logic                     i_temp_valid,
    input  logic [TIME_W-1:0]        i_now_ms,
    output t_chan_state              o_state,
    output t_result                  o_result
);
    logic                     enabled;
    logic                     is_open;
    logic                     railed;
    logic                     usable;
    logic [TIME_W-1:0]        range_age;
    logic [TIME_W-1:0]        heat_age;
    logic [TIME_W-1:0]        sustain;
    logic signed [TEMP_W-1:0] crit;
    logic signed [TEMP_W:0]   release_level;
    logic signed [TEMP_W:0]   temp_ext;
    logic                     heat_rise;
    t_event                   ev;
    t_chan_state              nxt;

    assign enabled  = i_cfg.enable_mask[i_channel];
    assign is_open  = i_voltage_code > i_cfg.open_level;
    assign railed   = is_open || (i_voltage_code < i_cfg.short_level);
    assign usable   = enabled && !railed && i_temp_valid;
    assign sustain  = TIME_W'(i_cfg.sustain_ms);
    assign range_age = i_now_ms - i_state.range_start;

    assign crit          = (i_channel == MOTOR_CH) ? i_cfg.crit_motor : i_cfg.crit_inverter;
    assign temp_ext      = (TEMP_W+1)'(i_temperature);
    assign release_level = (TEMP_W+1)'(crit) - $signed({1'b0, (TEMP_W)'(i_cfg.hysteresis)});

    always_comb begin
        nxt       = i_state;
        ev        = EV_NONE;
        heat_rise = 1'b0;
        heat_age  = '0;

        if (enabled) begin
            if (!railed) begin
                nxt.range_pending   = 1'b0;
                nxt.range_confirmed = 1'b0;
            end else if (!i_state.range_pending) begin
                nxt.range_pending = 1'b1;
                nxt.range_start   = i_now_ms;
            end else if (range_age >= sustain && !i_state.range_confirmed) begin
                nxt.range_confirmed = 1'b1;
                ev = is_open ? EV_OPEN : EV_SHORT;
            end
        end

        if (!usable || nxt.range_confirmed) begin
            nxt.heat_condition = 1'b0;
            nxt.heat_reported  = 1'b0;
        end else begin
            if (i_state.heat_condition) begin
                nxt.heat_condition = temp_ext > release_level;
            end else begin
                nxt.heat_condition = i_temperature > crit;
                heat_rise          = nxt.heat_condition;
                if (heat_rise) begin
                    nxt.heat_start = i_now_ms;
                end
            end
            // A fresh start means an age of zero.
            heat_age = heat_rise ? '0 : (i_now_ms - i_state.heat_start);
            if (!nxt.heat_condition) begin
                nxt.heat_reported = 1'b0;
            end else if (heat_age >= sustain && !i_state.heat_reported) begin
                nxt.heat_reported = 1'b1;
                ev = EV_OVER_TEMP;
            end
        end
    end

    assign o_state                   = nxt;
    assign o_result.range_fault      = nxt.range_confirmed;
    assign o_result.over_temp_active = nxt.heat_condition;
    assign o_result.temp_usable      = usable;
    assign o_result.fault_event      = ev;

endmodule

// File: design/temp_channel_fault_qualifier_top.sv
// Path: a request passes the evaluation stage registers, then the output register that drives m_axis.
// Throughput: one request per cycle unless m_axis stalls, including back-to-back requests for
// the same channel; the state memory is read at acceptance and written at evaluation, with a bypass path.
// Reset: configuration returns to its defaults and the per-channel valid bits clear, so
// every channel reads as all-zero state; there is no clearing pass and no busy time.
// Depends on tcfq_pkg, tcfq_cfg, tcfq_ram and tcfq_eval.
module temp_channel_fault_qualifier_top
    import tcfq_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // channel[1:0], voltage_code[17:2], temperature[30:18], temp_valid[31], now_ms[63:32]
    input  logic [63:0]           s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_channel[1:0], range_fault[2], over_temp_active[3], temp_usable[4],
    // fault_event[6:5], zero[7]
    output logic [7:0]            m_axis_tdata
);
    localparam int AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNTW = $clog2(CHANNELS + 1);
    localparam int CMPW = (CNTW > CH_W) ? CNTW : CH_W;

    t_cfg cfg;

    tcfq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_addr  (i_cfg_addr),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (cfg)
    );

    // Unpack the request.
    logic [CH_W-1:0]          in_channel;
    logic [VCODE_W-1:0]       in_vcode;
    logic signed [TEMP_W-1:0] in_temp;
    logic                     in_tvalid_flag;
    logic [TIME_W-1:0]        in_now;
    logic [AW-1:0]            in_addr;
    logic                     in_ch_ok;
    logic                     accept;

    assign in_channel     = s_axis_tdata[1:0];
    assign in_vcode       = s_axis_tdata[17:2];
    assign in_temp        = s_axis_tdata[30:18];
    assign in_tvalid_flag = s_axis_tdata[31];
    assign in_now         = s_axis_tdata[63:32];
    assign in_addr        = AW'(in_channel);
    assign in_ch_ok       = CMPW'(in_channel) < CMPW'(CHANNELS);

    // Evaluation stage registers.
    logic                     r_s1_valid;
    logic [CH_W-1:0]          r_s1_channel;
    logic [VCODE_W-1:0]       r_s1_vcode;
    logic signed [TEMP_W-1:0] r_s1_temp;
    logic                     r_s1_tvalid_flag;
    logic [TIME_W-1:0]        r_s1_now;
    logic [AW-1:0]            r_s1_addr;
    logic                     r_s1_ch_ok;
    logic                     r_s1_ent_valid;
    logic                     r_s1_byp;
    t_chan_state              r_s1_byp_data;
    logic [CHANNELS-1:0]      r_valid;

    logic                     r_out_valid;
    logic [CH_W-1:0]          r_out_channel;
    t_result                  r_out_res;

    logic                     s1_go;
    logic                     ram_we;
    logic [STATE_W-1:0]       ram_rdata;
    t_chan_state              cur_state;
    t_chan_state              new_state;
    t_result                  eval_res;
    logic                     same_entry;

    assign s1_go         = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_go;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign ram_we        = s1_go && r_s1_ch_ok;
    assign same_entry    = ram_we && (r_s1_addr == in_addr);

    tcfq_ram #(
        .WIDTH (STATE_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_addr),
        .i_wdata (new_state),
        .i_re    (accept && in_ch_ok),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    // A never-written entry reads as reset state; a write that lands in the same
    // cycle as the read of that entry is taken from the bypass register.
    always_comb begin
        if (!r_s1_ent_valid) begin
            cur_state = '0;
        end else if (r_s1_byp) begin
            cur_state = r_s1_byp_data;
        end else begin
            cur_state = t_chan_state'(ram_rdata);
        end
    end

    tcfq_eval u_eval (
        .i_cfg          (cfg),
        .i_state        (cur_state),
        .i_channel      (r_s1_channel),
        .i_voltage_code (r_s1_vcode),
        .i_temperature  (r_s1_temp),
        .i_temp_valid   (r_s1_tvalid_flag),
        .i_now_ms       (r_s1_now),
        .o_state        (new_state),
        .o_result       (eval_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (ram_we) begin
                r_valid[r_s1_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_channel     <= in_channel;
            r_s1_vcode       <= in_vcode;
            r_s1_temp        <= in_temp;
            r_s1_tvalid_flag <= in_tvalid_flag;
            r_s1_now         <= in_now;
            r_s1_addr        <= in_addr;
            r_s1_ch_ok       <= in_ch_ok;
            r_s1_byp         <= same_entry;
            r_s1_byp_data    <= new_state;
            r_s1_ent_valid   <= in_ch_ok && (r_valid[in_addr] || same_entry);
        end
        if (s1_go) begin
            r_out_channel <= r_s1_channel;
            r_out_res     <= r_s1_ch_ok ? eval_res : '0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_res.fault_event, r_out_res.temp_usable,
                            r_out_res.over_temp_active, r_out_res.range_fault,
                            r_out_channel};

    a_open_short_confirmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_res.fault_event == EV_OPEN || r_out_res.fault_event == EV_SHORT)
        |-> r_out_res.range_fault)
        else $error("open or short event without confirmed out-of-range");

    a_over_temp_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_res.fault_event == EV_OVER_TEMP
        |-> r_out_res.over_temp_active && r_out_res.temp_usable)
        else $error("over-temperature event on an inactive or unusable channel");

    a_usable_not_railed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_res.temp_usable |-> !r_out_res.range_fault)
        else $error("usable temperature on a channel confirmed out of range");

    a_bypass_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_byp |-> r_s1_ent_valid)
        else $error("bypassed state taken as never written");

    a_write_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> r_valid[$past(r_s1_addr)])
        else $error("state write did not mark its entry valid");

endmodule
